// ===== src/segpoly_pkg.sv =====
`default_nettype none
package segpoly_pkg;

	localparam int MAX_CORNERS = 8;
	localparam int IDX_W       = $clog2(MAX_CORNERS);
	localparam int CNT_W       = 4;
	localparam int COORD_W     = 32;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int CORNER_W    = 3 * COORD_W;
	localparam int NRM_W       = 2 * DIFF_W + 1;
	localparam int DOT_W       = 104;
	localparam int CHUNK_W     = 34;
	localparam int MA_W        = CHUNK_W + 1;
	localparam int MB_W        = DIFF_W + 1;
	localparam int PROD_W      = MA_W + MB_W;
	localparam int ACC_W       = 137;
	localparam int QUO_W       = 34;
	localparam int DIV_STEPS   = QUO_W;
	localparam int S_TDATA_W   = 296;
	localparam int M_TDATA_W   = 96;
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(3);
	localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(3);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_CORNERS);

	typedef struct packed {
		logic [COORD_W-1:0] z;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} corner_t;

	typedef enum logic [2:0] {A_E1, A_NLO, A_NHI, A_NUM, A_EX, A_EY} a_sel_t;
	typedef enum logic [2:0] {B_E2, B_D, B_CS, B_DABS, B_PY, B_PX} b_sel_t;
	typedef enum logic [1:0] {SH_0, SH_34, SH_68} sh_t;

	typedef struct packed {
		logic       start;
		logic       ld_c0;
		logic       ld_c1;
		logic       ld_cl;
		logic       ld_ea;
		logic       ld_eb;
		logic       adv_edge;
		logic       mac_en;
		logic       mac_clr;
		logic       mac_neg;
		sh_t        sh;
		a_sel_t     a_sel;
		logic [1:0] a_idx;
		b_sel_t     b_sel;
		logic [1:0] b_idx;
		logic [1:0] st_idx;
		logic       st_n;
		logic       st_den;
		logic       st_num;
		logic       fix_sign;
		logic       div_init;
		logic       div_step;
		logic       st_p;
		logic       edge_clr;
		logic       edge_eval;
		logic       ld_out;
		logic       out_miss;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
		logic miss;
	} dp_stat_t;

	function automatic logic [COORD_W-1:0] axis_of(input corner_t c, input logic [1:0] ax);
		logic [COORD_W-1:0] r;
		case (ax)
			2'd0: r = c.x;
			2'd1: r = c.y;
			default: r = c.z;
		endcase
		return r;
	endfunction

	function automatic logic [DIFF_W-1:0] diff33(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b);
		return {a[COORD_W-1], a} - {b[COORD_W-1], b};
	endfunction

endpackage
`default_nettype wire

// ===== src/segpoly_ram.sv =====
`default_nettype none
module segpoly_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== src/segpoly_ctrl.sv =====
`default_nettype none
module segpoly_ctrl
	import segpoly_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	input  wire logic             s_tuser,
	output logic                  s_tready,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata,
	input  wire dp_stat_t         stat,
	output dp_cmd_t               cmd,
	output logic      [IDX_W-1:0] raddr
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_FETCH, ST_NORM, ST_DEN, ST_NUM, ST_FIX, ST_CHK, ST_SMUL,
		ST_SDIV, ST_EFETCH, ST_EFIRST, ST_ELOAD, ST_EMUL, ST_EEVAL, ST_OUT
	} state_t;

	state_t           state_q, state_d;
	logic [5:0]       step_q, step_d;
	logic [1:0]       axis_q, axis_d;
	logic [IDX_W-1:0] ei_q, ei_d;
	logic             miss_q, miss_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_use;
	logic [IDX_W-1:0] last_idx;

	function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] j,
		input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] j1;
		j1 = CNT_W'(j) + CNT_W'(1);
		return (j1 == cnt) ? '0 : j1[IDX_W-1:0];
	endfunction

	// clamp the programmed count to a usable polygon
	always_comb begin
		if (cnt_q < CNT_MIN) begin
			cnt_use = CNT_MIN;
		end else if (cnt_q > CNT_MAX) begin
			cnt_use = CNT_MAX;
		end else begin
			cnt_use = cnt_q;
		end
		last_idx = IDX_W'(cnt_use - CNT_W'(1));
	end

	always_comb begin
		cmd      = '0;
		raddr    = '0;
		s_tready = 1'b0;
		state_d  = state_q;
		step_d   = step_q;
		axis_d   = axis_q;
		ei_d     = ei_q;
		miss_d   = miss_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser) begin
					cmd.start = 1'b1;
					state_d   = ST_FETCH;
					step_d    = '0;
				end
			end
			ST_FETCH: begin
				step_d = step_q + 6'd1;
				case (step_q[1:0])
					2'd0: raddr = '0;
					2'd1: begin
						raddr     = IDX_W'(1);
						cmd.ld_c0 = 1'b1;
					end
					2'd2: begin
						raddr     = last_idx;
						cmd.ld_c1 = 1'b1;
					end
					default: begin
						cmd.ld_cl = 1'b1;
						state_d   = ST_NORM;
						step_d    = '0;
					end
				endcase
			end
			ST_NORM: begin
				// n = e1 x e2, two products per component
				cmd.mac_en  = 1'b1;
				cmd.mac_clr = !step_q[0];
				cmd.mac_neg = step_q[0];
				cmd.a_sel   = A_E1;
				cmd.b_sel   = B_E2;
				cmd.sh      = SH_0;
				cmd.st_n    = step_q[0];
				cmd.st_idx  = step_q[2:1];
				case (step_q[2:0])
					3'd0: begin cmd.a_idx = 2'd1; cmd.b_idx = 2'd2; end
					3'd1: begin cmd.a_idx = 2'd2; cmd.b_idx = 2'd1; end
					3'd2: begin cmd.a_idx = 2'd2; cmd.b_idx = 2'd0; end
					3'd3: begin cmd.a_idx = 2'd0; cmd.b_idx = 2'd2; end
					3'd4: begin cmd.a_idx = 2'd0; cmd.b_idx = 2'd1; end
					default: begin cmd.a_idx = 2'd1; cmd.b_idx = 2'd0; end
				endcase
				step_d = step_q + 6'd1;
				if (step_q == 6'd5) begin
					state_d = ST_DEN;
					step_d  = '0;
				end
			end
			ST_DEN, ST_NUM: begin
				// wide normal component split in a low and a high half
				cmd.mac_en  = 1'b1;
				cmd.mac_clr = (step_q == 6'd0);
				cmd.a_sel   = step_q[0] ? A_NHI : A_NLO;
				cmd.sh      = step_q[0] ? SH_34 : SH_0;
				cmd.a_idx   = step_q[2:1];
				cmd.b_idx   = step_q[2:1];
				cmd.b_sel   = (state_q == ST_DEN) ? B_D : B_CS;
				step_d      = step_q + 6'd1;
				if (step_q == 6'd5) begin
					cmd.st_den = (state_q == ST_DEN);
					cmd.st_num = (state_q == ST_NUM);
					state_d    = (state_q == ST_DEN) ? ST_NUM : ST_FIX;
					step_d     = '0;
				end
			end
			ST_FIX: begin
				cmd.fix_sign = 1'b1;
				state_d      = ST_CHK;
			end
			ST_CHK: begin
				miss_d  = stat.miss;
				state_d = stat.miss ? ST_OUT : ST_SMUL;
				step_d  = '0;
				axis_d  = '0;
			end
			ST_SMUL: begin
				cmd.mac_en   = 1'b1;
				cmd.mac_clr  = (step_q == 6'd0);
				cmd.div_init = (step_q == 6'd0);
				cmd.a_sel    = A_NUM;
				cmd.a_idx    = step_q[1:0];
				cmd.sh       = sh_t'(step_q[1:0]);
				cmd.b_sel    = B_DABS;
				cmd.b_idx    = axis_q;
				step_d       = step_q + 6'd1;
				if (step_q == 6'd2) begin
					state_d = ST_SDIV;
					step_d  = '0;
				end
			end
			ST_SDIV: begin
				cmd.div_step = 1'b1;
				cmd.b_idx    = axis_q;
				cmd.st_idx   = axis_q;
				step_d       = step_q + 6'd1;
				if (step_q == 6'(DIV_STEPS - 1)) begin
					cmd.st_p = 1'b1;
					step_d   = '0;
					if (axis_q == 2'd2) begin
						state_d = ST_EFETCH;
					end else begin
						axis_d  = axis_q + 2'd1;
						state_d = ST_SMUL;
					end
				end
			end
			ST_EFETCH: begin
				raddr        = '0;
				cmd.edge_clr = 1'b1;
				ei_d         = '0;
				state_d      = ST_EFIRST;
			end
			ST_EFIRST: begin
				cmd.ld_ea = 1'b1;
				raddr     = nxt(ei_q, cnt_use);
				state_d   = ST_ELOAD;
			end
			ST_ELOAD: begin
				cmd.ld_eb = 1'b1;
				state_d   = ST_EMUL;
			end
			ST_EMUL: begin
				cmd.mac_en  = 1'b1;
				cmd.mac_clr = 1'b1;
				cmd.a_sel   = A_EX;
				cmd.b_sel   = B_PY;
				cmd.sh      = SH_0;
				state_d     = ST_EEVAL;
			end
			ST_EEVAL: begin
				cmd.mac_en    = 1'b1;
				cmd.mac_neg   = 1'b1;
				cmd.a_sel     = A_EY;
				cmd.b_sel     = B_PX;
				cmd.sh        = SH_0;
				cmd.edge_eval = 1'b1;
				if (ei_q == last_idx) begin
					state_d = ST_OUT;
				end else begin
					cmd.adv_edge = 1'b1;
					raddr        = nxt(ei_q + IDX_W'(1), cnt_use);
					ei_d         = ei_q + IDX_W'(1);
					state_d      = ST_ELOAD;
				end
			end
			ST_OUT: begin
				if (!stat.out_busy) begin
					cmd.ld_out   = 1'b1;
					cmd.out_miss = miss_q;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			axis_q  <= '0;
			ei_q    <= '0;
			miss_q  <= 1'b0;
			cnt_q   <= CNT_RESET;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			axis_q  <= axis_d;
			ei_q    <= ei_d;
			miss_q  <= miss_d;
			if (cfg_we) begin
				cnt_q <= cfg_wdata;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/segpoly_dp.sv =====
`default_nettype none
module segpoly_dp
	import segpoly_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	output dp_stat_t                stat,
	input  wire logic [COORD_W-1:0] send_x,
	input  wire logic [COORD_W-1:0] send_y,
	input  wire logic [COORD_W-1:0] send_z,
	input  wire logic [COORD_W-1:0] recv_x,
	input  wire logic [COORD_W-1:0] recv_y,
	input  wire logic [COORD_W-1:0] recv_z,
	input  wire corner_t            rdata,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit,
	output logic      [COORD_W-1:0] cross_x,
	output logic      [COORD_W-1:0] cross_y,
	output logic      [COORD_W-1:0] cross_z
);

	logic [COORD_W-1:0] s_q [3];
	logic [DIFF_W-1:0]  d_q [3];
	logic [NRM_W-1:0]   n_q [3];
	logic [COORD_W-1:0] p_q [3];
	corner_t            c0_q, c1_q, cl_q, ea_q, eb_q;
	logic [DOT_W-1:0]   den_q, num_q;
	logic [ACC_W-1:0]   acc_q, dsh_q, acc_next, term;
	logic [QUO_W-1:0]   q_q, q_next, q_signed;
	logic               inside_q, prev_pos_q, prev_neg_q, valid_q;

	logic [NRM_W-1:0]   n_a;
	logic [DIFF_W-1:0]  d_b;
	logic [COORD_W-1:0] s_b;
	logic [CHUNK_W-1:0] num_chunk;
	logic signed [MA_W-1:0]   a_op;
	logic signed [MB_W-1:0]   b_op;
	logic signed [PROD_W-1:0] prod;
	logic [ACC_W-1:0]   base;
	logic               ge;
	logic               r_neg, r_nz;
	logic [QUO_W-1:0]   p_sum;

	always_comb begin
		case (cmd.a_idx)
			2'd0: begin n_a = n_q[0]; num_chunk = num_q[CHUNK_W-1:0]; end
			2'd1: begin n_a = n_q[1]; num_chunk = num_q[2*CHUNK_W-1:CHUNK_W]; end
			default: begin n_a = n_q[2]; num_chunk = num_q[3*CHUNK_W-1:2*CHUNK_W]; end
		endcase
		case (cmd.b_idx)
			2'd0: begin d_b = d_q[0]; s_b = s_q[0]; end
			2'd1: begin d_b = d_q[1]; s_b = s_q[1]; end
			default: begin d_b = d_q[2]; s_b = s_q[2]; end
		endcase
	end

	always_comb begin
		case (cmd.a_sel)
			A_E1: a_op = MA_W'($signed(diff33(axis_of(c1_q, cmd.a_idx), axis_of(c0_q, cmd.a_idx))));
			A_NLO: a_op = {1'b0, n_a[CHUNK_W-1:0]};
			A_NHI: a_op = MA_W'($signed(n_a[NRM_W-1:CHUNK_W]));
			A_NUM: a_op = {1'b0, num_chunk};
			A_EX: a_op = MA_W'($signed(diff33(eb_q.x, ea_q.x)));
			A_EY: a_op = MA_W'($signed(diff33(eb_q.y, ea_q.y)));
			default: a_op = '0;
		endcase
		case (cmd.b_sel)
			B_E2: b_op = MB_W'($signed(diff33(axis_of(cl_q, cmd.b_idx), axis_of(c0_q, cmd.b_idx))));
			B_D: b_op = MB_W'($signed(d_b));
			B_CS: b_op = MB_W'($signed(diff33(axis_of(c0_q, cmd.b_idx), s_b)));
			B_DABS: b_op = {1'b0, d_b[DIFF_W-1] ? -d_b : d_b};
			B_PY: b_op = MB_W'($signed(diff33(p_q[1], ea_q.y)));
			B_PX: b_op = MB_W'($signed(diff33(p_q[0], ea_q.x)));
			default: b_op = '0;
		endcase
		prod = a_op * b_op;
	end

	always_comb begin
		case (cmd.sh)
			SH_34: term = ACC_W'(prod) << CHUNK_W;
			SH_68: term = ACC_W'(prod) << (2 * CHUNK_W);
			default: term = ACC_W'(prod);
		endcase
		base = cmd.mac_clr ? '0 : acc_q;
		// restoring division step, the remainder lives in the accumulator
		ge     = (acc_q >= dsh_q);
		q_next = {q_q[QUO_W-2:0], ge};
		if (cmd.div_step) begin
			acc_next = ge ? (acc_q - dsh_q) : acc_q;
		end else if (cmd.mac_en) begin
			acc_next = cmd.mac_neg ? (base - term) : (base + term);
		end else begin
			acc_next = acc_q;
		end
		r_neg    = acc_next[ACC_W-1];
		r_nz     = |acc_next;
		q_signed = d_b[DIFF_W-1] ? -q_next : q_next;
		p_sum    = QUO_W'($signed(s_b)) + q_signed;
	end

	assign stat.miss = (den_q == '0) || num_q[DOT_W-1] || ($signed(num_q) > $signed(den_q));
	assign stat.out_busy = valid_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			s_q[0] <= send_x;
			s_q[1] <= send_y;
			s_q[2] <= send_z;
			d_q[0] <= diff33(recv_x, send_x);
			d_q[1] <= diff33(recv_y, send_y);
			d_q[2] <= diff33(recv_z, send_z);
		end
		if (cmd.ld_c0) c0_q <= rdata;
		if (cmd.ld_c1) c1_q <= rdata;
		if (cmd.ld_cl) cl_q <= rdata;
		if (cmd.ld_ea) begin
			ea_q <= rdata;
		end else if (cmd.adv_edge) begin
			ea_q <= eb_q;
		end
		if (cmd.ld_eb) eb_q <= rdata;
		acc_q <= acc_next;
		if (cmd.st_n) begin
			case (cmd.st_idx)
				2'd0: n_q[0] <= acc_next[NRM_W-1:0];
				2'd1: n_q[1] <= acc_next[NRM_W-1:0];
				default: n_q[2] <= acc_next[NRM_W-1:0];
			endcase
		end
		if (cmd.st_den) den_q <= acc_next[DOT_W-1:0];
		if (cmd.st_num) num_q <= acc_next[DOT_W-1:0];
		if (cmd.fix_sign && den_q[DOT_W-1]) begin
			den_q <= -den_q;
			num_q <= -num_q;
		end
		if (cmd.div_init) begin
			dsh_q <= {den_q, (ACC_W - DOT_W)'(0)};
			q_q   <= '0;
		end else if (cmd.div_step) begin
			dsh_q <= dsh_q >> 1;
			q_q   <= q_next;
		end
		if (cmd.st_p) begin
			case (cmd.st_idx)
				2'd0: p_q[0] <= p_sum[COORD_W-1:0];
				2'd1: p_q[1] <= p_sum[COORD_W-1:0];
				default: p_q[2] <= p_sum[COORD_W-1:0];
			endcase
		end
		if (cmd.edge_clr) begin
			inside_q   <= 1'b1;
			prev_pos_q <= 1'b0;
			prev_neg_q <= 1'b0;
		end else if (cmd.edge_eval) begin
			// zero cross sign means the point is on the edge line
			if ((prev_pos_q && r_neg) || (prev_neg_q && r_nz && !r_neg)) begin
				inside_q <= 1'b0;
			end
			if (r_nz) begin
				prev_pos_q <= !r_neg;
				prev_neg_q <= r_neg;
			end
		end
		if (cmd.ld_out) begin
			hit     <= !cmd.out_miss && inside_q;
			cross_x <= cmd.out_miss ? '0 : p_q[0];
			cross_y <= cmd.out_miss ? '0 : p_q[1];
			cross_z <= cmd.out_miss ? '0 : p_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;

endmodule
`default_nettype wire

// ===== src/segment_polygon_intersection.sv =====
`default_nettype none
// Tests a 3D segment against a convex polygon of up to eight corners. A load item
// (tuser 0) writes one corner. A query item (tuser 1) returns one result item: the
// plane crossing point truncated toward zero and a hit flag that is set when the point's
// XY projection lies inside or on the polygon. A plane miss returns hit 0 and a zero point.
// A query is computed on the one shared 35x34 multiply-accumulate unit and the
// one-bit-per-cycle restoring divider that forms each coordinate of the crossing point.
// The result waits in an output register, so a new item is taken as soon as the
// previous query's result has entered that register.
module segment_polygon_intersection
	import segpoly_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// corner_index, corner_x, corner_y, corner_z, send_x, send_y, send_z,
	// recv_x, recv_y, recv_z, zero pad
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// cmd
	input  wire logic                 s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// cross_x, cross_y, cross_z
	output logic      [M_TDATA_W-1:0] m_tdata,
	// hit
	output logic                      m_tuser,
	input  wire logic                 cfg_we,
	input  wire logic [CNT_W-1:0]     cfg_wdata
);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [IDX_W-1:0] raddr;
	corner_t          rdata;
	logic             ram_we;

	assign ram_we = s_tvalid && s_tready && !s_tuser;

	segpoly_ram #(
		.WIDTH(CORNER_W),
		.DEPTH(MAX_CORNERS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (s_tdata[IDX_W-1:0]),
		.wdata (s_tdata[IDX_W+CORNER_W-1:IDX_W]),
		.raddr (raddr),
		.rdata (rdata)
	);

	segpoly_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tuser   (s_tuser),
		.s_tready  (s_tready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.cmd       (cmd),
		.raddr     (raddr)
	);

	segpoly_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.send_x    (s_tdata[130:99]),
		.send_y    (s_tdata[162:131]),
		.send_z    (s_tdata[194:163]),
		.recv_x    (s_tdata[226:195]),
		.recv_y    (s_tdata[258:227]),
		.recv_z    (s_tdata[290:259]),
		.rdata     (rdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.hit       (m_tuser),
		.cross_x   (m_tdata[31:0]),
		.cross_y   (m_tdata[63:32]),
		.cross_z   (m_tdata[95:64])
	);

endmodule
`default_nettype wire

// ===== src/segpoly_chk.sv =====
`default_nettype none
module segpoly_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic s_tuser,
	input wire logic m_tvalid,
	input wire logic m_tready
);

	// a result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before it was taken");

	// a query keeps the input side closed while it is computed
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("input taken during a query");

	// a corner load produces no result item
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid)
		else $error("result item from a corner load");

	// a new result appears only as the block goes back to taking items
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result shown while still busy");

endmodule

bind segment_polygon_intersection segpoly_chk u_chk (.*);
`default_nettype wire

// ===== verif/segment_polygon_intersection_tb.sv =====
module segment_polygon_intersection_tb;
	import segpoly_pkg::*;

	typedef logic signed [191:0] wint;
	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct {
		logic   query;
		logic [IDX_W-1:0] idx;
		coord_t c[3];
		coord_t s[3];
		coord_t r[3];
	} seg_item_t;

	typedef struct {
		logic   hit;
		coord_t p[3];
	} crossing_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 cfg_we;
	logic [CNT_W-1:0]     cfg_wdata;

	segment_polygon_intersection dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	coord_t          poly_x[MAX_CORNERS], poly_y[MAX_CORNERS], poly_z[MAX_CORNERS];
	logic [CNT_W-1:0] corner_cnt;

	seg_item_t pending_items[$];
	crossing_t expected_crossings[$];
	seg_item_t held_item;

	int mismatches, queries_done, hits_seen, loads_done;
	int cycle_no;
	logic calm, hold_off;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) cycle_no <= cycle_no + 1;

	function automatic void queue_item(input seg_item_t it);
		pending_items = {pending_items, it};
	endfunction

	function automatic crossing_t predict_crossing(input seg_item_t q);
		crossing_t res;
		int cnt, last, nxt, prev, sg;
		wint sx, sy, sz, dx, dy, dz, e1x, e1y, e1z, e2x, e2y, e2z;
		wint nx, ny, nz, den, num, px, py, pz, ex, ey, cr;
		logic in_poly;
		cnt = corner_cnt < CNT_MIN ? 3 : (corner_cnt > CNT_MAX ? MAX_CORNERS : corner_cnt);
		last = cnt - 1;
		sx = wint'(q.s[0]); sy = wint'(q.s[1]); sz = wint'(q.s[2]);
		dx = wint'(q.r[0]) - sx; dy = wint'(q.r[1]) - sy; dz = wint'(q.r[2]) - sz;
		e1x = wint'(poly_x[1]) - wint'(poly_x[0]);
		e1y = wint'(poly_y[1]) - wint'(poly_y[0]);
		e1z = wint'(poly_z[1]) - wint'(poly_z[0]);
		e2x = wint'(poly_x[last]) - wint'(poly_x[0]);
		e2y = wint'(poly_y[last]) - wint'(poly_y[0]);
		e2z = wint'(poly_z[last]) - wint'(poly_z[0]);
		nx = e1y * e2z - e1z * e2y;
		ny = e1z * e2x - e1x * e2z;
		nz = e1x * e2y - e1y * e2x;
		den = nx * dx + ny * dy + nz * dz;
		num = nx * (wint'(poly_x[0]) - sx) + ny * (wint'(poly_y[0]) - sy)
			+ nz * (wint'(poly_z[0]) - sz);
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		res.hit = 1'b0;
		res.p[0] = '0; res.p[1] = '0; res.p[2] = '0;
		if (den == 0 || num < 0 || num > den)
			return res;
		// truncation toward zero: scale the magnitude, then restore the sign
		px = sx + (dx < 0 ? -(((-dx) * num) / den) : (dx * num) / den);
		py = sy + (dy < 0 ? -(((-dy) * num) / den) : (dy * num) / den);
		pz = sz + (dz < 0 ? -(((-dz) * num) / den) : (dz * num) / den);
		in_poly = 1'b1;
		prev = 0;
		for (int i = 0; i < cnt; i++) begin
			nxt = (i + 1 == cnt) ? 0 : i + 1;
			ex = wint'(poly_x[nxt]) - wint'(poly_x[i]);
			ey = wint'(poly_y[nxt]) - wint'(poly_y[i]);
			cr = ex * (py - wint'(poly_y[i])) - ey * (px - wint'(poly_x[i]));
			sg = cr > 0 ? 1 : (cr < 0 ? -1 : 0);
			if ((prev > 0 && sg < 0) || (prev < 0 && sg > 0)) begin
				in_poly = 1'b0;
				break;
			end
			if (sg != 0) prev = sg;
		end
		res.hit = in_poly;
		res.p[0] = px[COORD_W-1:0];
		res.p[1] = py[COORD_W-1:0];
		res.p[2] = pz[COORD_W-1:0];
		return res;
	endfunction

	function automatic logic [S_TDATA_W-1:0] pack_item(input seg_item_t it);
		return {5'b0, it.r[2], it.r[1], it.r[0], it.s[2], it.s[1], it.s[0],
			it.c[2], it.c[1], it.c[0], it.idx};
	endfunction

	// driver: accepted item goes through the predictor, then the next is offered
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (held_item.query) begin
					expected_crossings = {expected_crossings, predict_crossing(held_item)};
					queries_done++;
				end else begin
					poly_x[held_item.idx] = held_item.c[0];
					poly_y[held_item.idx] = held_item.c[1];
					poly_z[held_item.idx] = held_item.c[2];
					loads_done++;
				end
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
					held_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= pack_item(held_item);
					s_tuser  <= held_item.query;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		crossing_t want;
		if (arst_n)
			m_tready <= hold_off ? 1'b0 : (calm || $urandom_range(99) >= 17);
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_crossings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: hit %0b data %h", m_tuser, m_tdata);
			end else begin
				want = expected_crossings.pop_front();
				if (want.hit) hits_seen++;
				if (m_tuser !== want.hit || m_tdata !== {want.p[2], want.p[1], want.p[0]}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected hit %0b x %0d y %0d z %0d, got hit %0b x %0d y %0d z %0d",
							want.hit, want.p[0], want.p[1], want.p[2], m_tuser,
							$signed(m_tdata[31:0]), $signed(m_tdata[63:32]),
							$signed(m_tdata[95:64]));
				end
			end
		end
	end

	// no idling on either side in this stretch
	always @(posedge clk) calm <= (cycle_no >= 30000 && cycle_no < 45000);

	// long receiver hold-off so the block backs up into its input
	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		repeat (6000) @(posedge clk);
		hold_off = 1'b1;
		repeat (2000) @(posedge clk);
		hold_off = 1'b0;
	end

	function automatic seg_item_t noise_item(input logic query);
		seg_item_t it;
		it.query = query;
		it.idx = IDX_W'($urandom);
		for (int a = 0; a < 3; a++) begin
			it.c[a] = $urandom;
			it.s[a] = $urandom;
			it.r[a] = $urandom;
		end
		return it;
	endfunction

	function automatic seg_item_t load_item(input int idx, input coord_t x, input coord_t y,
		input coord_t z);
		seg_item_t it;
		it = noise_item(1'b0);
		it.idx = IDX_W'(idx);
		it.c[0] = x; it.c[1] = y; it.c[2] = z;
		return it;
	endfunction

	function automatic seg_item_t query_item(input coord_t sx, input coord_t sy, input coord_t sz,
		input coord_t rx, input coord_t ry, input coord_t rz);
		seg_item_t it;
		it = noise_item(1'b1);
		it.s[0] = sx; it.s[1] = sy; it.s[2] = sz;
		it.r[0] = rx; it.r[1] = ry; it.r[2] = rz;
		return it;
	endfunction

	function automatic int spread(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	task automatic write_count(input logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		corner_cnt = v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || s_tvalid || expected_crossings.size() > 0)
			@(posedge clk);
		// a trailing load may still be in flight
		repeat (250) @(posedge clk);
	endtask

	// one convex polygon in the active count followed by a burst of queries and stray corner loads
	task automatic polygon_burst(input int cnt);
		int cxr, cyr, czr, rad, h, nq, span;
		real ph, ang;
		span = ($urandom_range(9) == 0) ? 1000000000 : 1000000;
		rad = ($urandom_range(9) == 0) ? int'($urandom_range(100000000, 10))
			: int'($urandom_range(span / 2, 10));
		cxr = spread(span); cyr = spread(span); czr = spread(span);
		ph = $urandom_range(1000) / 160.0;
		if ($urandom_range(19) == 0) begin
			// degenerate: all corners coincide
			for (int i = 0; i < MAX_CORNERS; i++)
				queue_item(load_item(i, cxr, cyr, czr));
		end else begin
			for (int i = 0; i < cnt; i++) begin
				ang = ph + 6.283185307 * i / cnt;
				queue_item(load_item(i, cxr + $rtoi(rad * $cos(ang)),
					cyr + $rtoi(rad * $sin(ang)), czr + spread(rad / 4 + 1)));
			end
		end
		nq = $urandom_range(14, 6);
		for (int k = 0; k < nq; k++) begin
			h = $urandom_range(2000000, 1);
			case ($urandom_range(9))
				0: queue_item(noise_item(1'b1));
				1: queue_item(load_item($urandom_range(7), $urandom, $urandom,
					$urandom));
				2: begin
					// segment parallel to the xy plane or too short to reach it
					queue_item(query_item(cxr, cyr, czr + h, cxr + spread(rad),
						cyr + spread(rad), czr + h + spread(h) / 2));
				end
				default: begin
					if ($urandom_range(1))
						queue_item(query_item(cxr + spread(rad), cyr + spread(rad),
							czr + h, cxr + spread(rad), cyr + spread(rad), czr - spread(h) - h));
					else
						queue_item(query_item(cxr + spread(rad), cyr + spread(rad),
							czr - h, cxr + spread(rad), cyr + spread(rad), czr + h));
				end
			endcase
		end
	endtask

	initial begin
		logic [CNT_W-1:0] counts[12];
		int goal;
		counts = '{4'd8, 4'd0, 4'd15, 4'd5, 4'd4, 4'd6, 4'd7, 4'd1, 4'd3, 4'd2, 4'd8, 4'd12};
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
		m_tready = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
		corner_cnt = CNT_RESET;
		mismatches = 0; queries_done = 0; hits_seen = 0; loads_done = 0; cycle_no = 0;
		for (int i = 0; i < MAX_CORNERS; i++) begin
			poly_x[i] = '0; poly_y[i] = '0; poly_z[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		write_count(4'd3);

		// directed: a small triangle, extreme corners, degenerate plane
		queue_item(load_item(0, 0, 0, 0));
		queue_item(load_item(1, 1000, 0, 0));
		queue_item(load_item(2, 0, 1000, 0));
		for (int i = 3; i < MAX_CORNERS; i++)
			queue_item(load_item(i, 32'h8000_0000, 32'h7fff_ffff,
				(i % 2) ? 32'h8000_0000 : 32'h7fff_ffff));
		queue_item(query_item(100, 100, 500, 100, 100, -500));
		queue_item(query_item(1000, 0, 7, 1000, 0, -3));
		queue_item(query_item(500, 500, -9, 500, 500, 9));
		queue_item(query_item(2000, 2000, 10, 2000, 2000, -10));
		queue_item(query_item(100, 100, 50, 300, 100, 50));
		queue_item(query_item(100, 100, 50, 100, 100, 20));
		queue_item(query_item(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
		queue_item(load_item(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		queue_item(load_item(1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
		queue_item(load_item(2, 32'h8000_0000, 32'h7fff_ffff, 32'h0));
		queue_item(query_item(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
		queue_item(query_item(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
		queue_item(load_item(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		queue_item(query_item(0, 0, 100, 0, 0, -100));
		drain();

		foreach (counts[ph]) begin
			write_count(counts[ph]);
			// every corner gets written so no query reads an empty entry
			for (int i = 0; i < MAX_CORNERS; i++)
				queue_item(load_item(i, $urandom, $urandom, $urandom));
			goal = 115;
			while (goal > 0) begin
				int before_n;
				before_n = pending_items.size();
				polygon_burst(counts[ph] < CNT_MIN ? 3
					: (counts[ph] > CNT_MAX ? MAX_CORNERS : counts[ph]));
				goal -= pending_items.size() - before_n;
			end
			drain();
		end

		$display("covered %0d corner loads and %0d queries over %0d corner counts, %0d hits",
			loads_done, queries_done, $size(counts) + 1, hits_seen);
		if (mismatches == 0 && expected_crossings.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#30000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
